@@ rtl/ws2812_matrix_frame_buffer_defines.svh @@
// Assertion macros for the WS2812 matrix frame buffer checker.
// Depends on nothing; included by the checker file only.
`ifndef WS2812_MATRIX_FRAME_BUFFER_DEFINES_SVH
`define WS2812_MATRIX_FRAME_BUFFER_DEFINES_SVH

// same-cycle implication
`define WMFB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define WMFB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/wmfb_pkg.sv @@
// Shared types and constants for the WS2812 matrix frame buffer.
// Used by every module of the block; depends on nothing.
package wmfb_pkg;

   localparam int MATRIX_COLS    = 16;
   localparam int MATRIX_ROWS    = 16;
   localparam int NUM_CHANNELS   = 4;
   localparam int BITS_PER_PIXEL = 24;

   localparam int PIXEL_COUNT = MATRIX_COLS * MATRIX_ROWS;
   localparam int PIX_PER_CH  = (PIXEL_COUNT + NUM_CHANNELS - 1) / NUM_CHANNELS;
   localparam int DATA_SLOTS  = PIX_PER_CH * BITS_PER_PIXEL;
   localparam int ADDR_W      = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
   localparam int PIX_W       = $clog2(NUM_CHANNELS * PIX_PER_CH + 256) + 1;

   localparam int REQ_TDATA_W = 56;
   localparam int RSP_TDATA_W = 16;

   localparam logic [3:0] ALL_BUSY  = 4'((1 << NUM_CHANNELS) - 1);
   localparam logic [2:0] CMP_NONE  = 3'd0;
   localparam logic [2:0] CMP_ZERO  = 3'd3;
   localparam logic [2:0] CMP_ONE   = 3'd6;

   typedef enum logic [2:0] {
      CMD_SET_PIXEL    = 3'd0,
      CMD_CLEAR        = 3'd1,
      CMD_TICK         = 3'd2,
      CMD_CHANNEL_DONE = 3'd3,
      CMD_READ_ENTRY   = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      RD_NONE  = 2'd0,
      RD_BLACK = 2'd1,
      RD_DATA  = 2'd2
   } rd_kind_type;

   typedef enum logic [1:0] {
      BYTE_GREEN = 2'd0,
      BYTE_RED   = 2'd1,
      BYTE_BLUE  = 2'd2
   } byte_sel_type;

   typedef struct packed {
      cmd_type     command;
      logic [7:0]  column;
      logic [7:0]  row_index;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [1:0]  out_channel;
      logic [10:0] slot_index;
   } req_item_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [23:0]       wr_data;
      logic              clr_all;
      logic [ADDR_W-1:0] rd_addr;
   } store_req_type;

   typedef struct packed {
      logic [23:0] data;
      logic        vld;
   } store_rd_type;

   typedef struct packed {
      rd_kind_type  kind;
      byte_sel_type byte_sel;
      logic [2:0]   bit_pos;
      logic         start;
      logic [3:0]   busy;
      logic         request;
   } meta_type;

endpackage

@@ rtl/wmfb_ctrl.sv @@
// Input register, command decode and flag/busy state of the frame buffer.
// Depends on wmfb_pkg; feeds wmfb_store and wmfb_out.
module wmfb_ctrl (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [wmfb_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic                             adv2,
   output wmfb_pkg::store_req_type          store_req,
   output wmfb_pkg::meta_type               meta,
   output logic                             meta_valid
);
   import wmfb_pkg::*;

   logic         v1_ff, v1_in;
   req_item_type item_ff, item_in;
   logic         req_flag_ff, req_flag_in;
   logic [3:0]   mask_ff, mask_in;

   logic              fire;
   logic              in_range;
   logic [7:0]        col_eff;
   logic [15:0]       idx_wide;
   logic [7:0]        slot_hi;
   logic [15:0]       q_prod;
   logic [7:0]        q;
   logic [1:0]        r3;
   logic [PIX_W-1:0]  pix;

   assign req_tready = !v1_ff || adv2;
   assign fire       = v1_ff && adv2;
   assign meta_valid = v1_ff;

   always_comb begin
      item_in             = item_ff;
      v1_in               = v1_ff;
      if (req_tready) begin
         v1_in               = req_tvalid;
         item_in.command     = cmd_type'(req_tdata[2:0]);
         item_in.column      = req_tdata[10:3];
         item_in.row_index   = req_tdata[18:11];
         item_in.red         = req_tdata[26:19];
         item_in.green       = req_tdata[34:27];
         item_in.blue        = req_tdata[42:35];
         item_in.out_channel = req_tdata[44:43];
         item_in.slot_index  = req_tdata[55:45];
      end
   end

   always_comb begin
      in_range = (item_ff.column < MATRIX_COLS) && (item_ff.row_index < MATRIX_ROWS);
      col_eff  = item_ff.row_index[0] ? 8'(MATRIX_COLS - 1) - item_ff.column
                                      : item_ff.column;
      idx_wide = {8'b0, col_eff} + 16'(item_ff.row_index * MATRIX_COLS);

      slot_hi = item_ff.slot_index[10:3];
      q_prod  = 16'(slot_hi) * 16'd171;
      q       = 8'(q_prod >> 9);
      r3      = 2'(slot_hi - 8'(q * 8'd3));
      pix     = PIX_W'(item_ff.out_channel) * PIX_W'(PIX_PER_CH) + PIX_W'(q);
   end

   always_comb begin
      store_req.wr_en   = 1'b0;
      store_req.wr_addr = idx_wide[ADDR_W-1:0];
      store_req.wr_data = {item_ff.red, item_ff.green, item_ff.blue};
      store_req.clr_all = 1'b0;
      store_req.rd_addr = pix[ADDR_W-1:0];
      req_flag_in       = req_flag_ff;
      mask_in           = mask_ff;
      meta.start        = 1'b0;
      meta.kind         = RD_NONE;
      unique case (r3)
         2'd0:    meta.byte_sel = BYTE_GREEN;
         2'd1:    meta.byte_sel = BYTE_RED;
         default: meta.byte_sel = BYTE_BLUE;
      endcase
      meta.bit_pos = 3'd7 - item_ff.slot_index[2:0];
      if (fire) begin
         unique case (item_ff.command)
            CMD_SET_PIXEL: begin
               if (in_range) begin
                  store_req.wr_en = 1'b1;
                  req_flag_in     = 1'b1;
               end
            end
            CMD_CLEAR: begin
               store_req.clr_all = 1'b1;
               req_flag_in       = 1'b1;
            end
            CMD_TICK: begin
               if (req_flag_ff && (mask_ff == 4'b0)) begin
                  req_flag_in = 1'b0;
                  mask_in     = ALL_BUSY;
                  meta.start  = 1'b1;
               end
            end
            CMD_CHANNEL_DONE: begin
               if (int'(item_ff.out_channel) < NUM_CHANNELS) begin
                  mask_in = mask_ff ^ (4'b1 << item_ff.out_channel);
               end
            end
            CMD_READ_ENTRY: begin
               priority if ((int'(item_ff.out_channel) >= NUM_CHANNELS) ||
                            (int'(item_ff.slot_index) >= DATA_SLOTS)) begin
                  meta.kind = RD_NONE;
               end else if (int'(pix) >= PIXEL_COUNT) begin
                  meta.kind = RD_BLACK;
               end else begin
                  meta.kind = RD_DATA;
               end
            end
            default: begin
            end
         endcase
      end
      meta.busy    = mask_in;
      meta.request = req_flag_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff       <= 1'b0;
         req_flag_ff <= 1'b1;
         mask_ff     <= 4'b0;
      end else begin
         v1_ff       <= v1_in;
         req_flag_ff <= req_flag_in;
         mask_ff     <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

endmodule

@@ rtl/wmfb_store.sv @@
// Pixel color memory with per-entry written bits and registered read port.
// Depends on wmfb_pkg; driven by wmfb_ctrl, read by wmfb_out.
module wmfb_store (
   input  logic                    clock,
   input  logic                    reset,
   input  wmfb_pkg::store_req_type store_req,
   input  logic                    adv2,
   output wmfb_pkg::store_rd_type  store_rd
);
   import wmfb_pkg::*;

   logic [23:0]            pixel_mem [PIXEL_COUNT];
   logic [PIXEL_COUNT-1:0] valid_ff, valid_in;
   logic [23:0]            rd_data_ff;
   logic                   rd_vld_ff;

   always_comb begin
      valid_in = valid_ff;
      if (store_req.clr_all) begin
         valid_in = '0;
      end else if (store_req.wr_en) begin
         valid_in[store_req.wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store_req.wr_en) begin
         pixel_mem[store_req.wr_addr] <= store_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (adv2) begin
         rd_data_ff <= pixel_mem[store_req.rd_addr];
         rd_vld_ff  <= valid_ff[store_req.rd_addr];
      end
   end

   assign store_rd.data = rd_data_ff;
   assign store_rd.vld  = rd_vld_ff;

endmodule

@@ rtl/wmfb_out.sv @@
// Compare-value select and result register with stall handling.
// Depends on wmfb_pkg; takes decode from wmfb_ctrl and data from wmfb_store.
module wmfb_out (
   input  logic                             clock,
   input  logic                             reset,
   input  wmfb_pkg::meta_type               meta,
   input  logic                             meta_valid,
   input  wmfb_pkg::store_rd_type           store_rd,
   output logic                             adv2,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [wmfb_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import wmfb_pkg::*;

   logic                   v2_ff, v2_in;
   meta_type               meta2_ff, meta2_in;
   logic                   v3_ff, v3_in;
   logic [RSP_TDATA_W-1:0] res_ff, res_in;

   logic        adv3;
   logic [23:0] color;
   logic [7:0]  byte_val;
   logic [2:0]  cmp;

   assign adv3 = !v3_ff || rsp_tready;
   assign adv2 = !v2_ff || adv3;

   always_comb begin
      color = store_rd.vld ? store_rd.data : 24'b0;
      unique case (meta2_ff.byte_sel)
         BYTE_GREEN: byte_val = color[15:8];
         BYTE_RED:   byte_val = color[23:16];
         default:    byte_val = color[7:0];
      endcase
      unique case (meta2_ff.kind)
         RD_BLACK: cmp = CMP_ZERO;
         RD_DATA:  cmp = byte_val[meta2_ff.bit_pos] ? CMP_ONE : CMP_ZERO;
         default:  cmp = CMP_NONE;
      endcase
   end

   always_comb begin
      v2_in    = v2_ff;
      meta2_in = meta2_ff;
      if (adv2) begin
         v2_in    = meta_valid;
         meta2_in = meta;
      end
      v3_in  = v3_ff;
      res_in = res_ff;
      if (adv3) begin
         v3_in  = v2_ff;
         res_in = {7'b0, meta2_ff.request, meta2_ff.busy, meta2_ff.start, cmp};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      meta2_ff <= meta2_in;
      res_ff   <= res_in;
   end

   assign rsp_tvalid = v3_ff;
   assign rsp_tdata  = res_ff;

endmodule

@@ rtl/ws2812_matrix_frame_buffer.sv @@
// WS2812 matrix frame buffer: an accepted word passes through the input register, the memory
// read register and the result register; one word per cycle sustained while rsp_tready is high,
// with at most one pixel memory write and one read per word.
// Synchronous reset empties the pipeline, sets the request flag, clears the busy bits and
// marks every pixel black through per-pixel written bits, so no clearing pass is needed.
// Top level; depends on wmfb_pkg, wmfb_ctrl, wmfb_store and wmfb_out.
module ws2812_matrix_frame_buffer (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // command, column, row_index, red, green, blue, out_channel, slot_index
   input  logic [wmfb_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // compare_value, transfer_start, busy_mask, request_pending, zero fill
   output logic [wmfb_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import wmfb_pkg::*;

   store_req_type store_req;
   store_rd_type  store_rd;
   meta_type      meta;
   logic          meta_valid;
   logic          adv2;

   wmfb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .adv2       (adv2),
      .store_req  (store_req),
      .meta       (meta),
      .meta_valid (meta_valid)
   );

   wmfb_store u_store (
      .clock     (clock),
      .reset     (reset),
      .store_req (store_req),
      .adv2      (adv2),
      .store_rd  (store_rd)
   );

   wmfb_out u_out (
      .clock      (clock),
      .reset      (reset),
      .meta       (meta),
      .meta_valid (meta_valid),
      .store_rd   (store_rd),
      .adv2       (adv2),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

@@ rtl/wmfb_checker.sv @@
// Port-level assertions for the WS2812 matrix frame buffer, bound to the top level.
// Depends on wmfb_pkg and ws2812_matrix_frame_buffer_defines.svh.
`include "ws2812_matrix_frame_buffer_defines.svh"

module wmfb_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [wmfb_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import wmfb_pkg::*;

   `WMFB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "result word changed while stalled")
   `WMFB_ASSERT_NOW(a_start_sets_busy, clock, reset, rsp_tvalid && rsp_tdata[3], (rsp_tdata[7:4] == ALL_BUSY) && !rsp_tdata[8], "start without all busy and request dropped")
   `WMFB_ASSERT_NOW(a_cmp_legal, clock, reset, rsp_tvalid, (rsp_tdata[2:0] == CMP_NONE) || (rsp_tdata[2:0] == CMP_ZERO) || (rsp_tdata[2:0] == CMP_ONE), "illegal compare value")
   `WMFB_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid, "result word right after reset")

endmodule

bind ws2812_matrix_frame_buffer wmfb_checker u_wmfb_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

@@ dv/tb.sv @@
// Self-checking bench for the WS2812 matrix frame buffer: drives command words, predicts each
// status word from its own copy of the pixel store and busy/request state, and checks results.
// Depends on wmfb_pkg and ws2812_matrix_frame_buffer.
module tb;
   import wmfb_pkg::*;

   typedef struct packed {
      logic [2:0] compare;
      logic       start;
      logic [3:0] busy;
      logic       request;
   } strip_status_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   logic [REQ_TDATA_W-1:0] outgoing_words[$];
   strip_status_type       status_expected[$];

   logic [23:0] frame_pixels[PIXEL_COUNT];
   logic        request_model;
   logic [3:0]  busy_model;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int fault_count    = 0;

   ws2812_matrix_frame_buffer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [REQ_TDATA_W-1:0] pack_word(input logic [2:0] cmd,
         input logic [7:0] col, input logic [7:0] row, input logic [7:0] r,
         input logic [7:0] g, input logic [7:0] b, input logic [1:0] ch,
         input logic [10:0] slot);
      return {slot, ch, b, g, r, row, col, cmd};
   endfunction

   function automatic logic [2:0] slot_compare(input int ch, input int slot);
      int          pix;
      logic [23:0] colour;
      logic [7:0]  colour_byte;
      if (ch >= NUM_CHANNELS || slot >= DATA_SLOTS) return CMP_NONE;
      pix = ch * PIX_PER_CH + slot / BITS_PER_PIXEL;
      if (pix >= PIXEL_COUNT) return CMP_ZERO;
      colour = frame_pixels[pix];
      case ((slot % BITS_PER_PIXEL) / 8)
         0: colour_byte = colour[15:8];
         1: colour_byte = colour[23:16];
         default: colour_byte = colour[7:0];
      endcase
      return colour_byte[7 - (slot % 8)] ? CMP_ONE : CMP_ZERO;
   endfunction

   task automatic apply_command(input logic [REQ_TDATA_W-1:0] w, output strip_status_type st);
      int col;
      int row;
      int idx;
      col = int'(w[10:3]);
      row = int'(w[18:11]);
      st = '0;
      case (w[2:0])
         CMD_SET_PIXEL: begin
            if (col < MATRIX_COLS && row < MATRIX_ROWS) begin
               if (row % 2 == 1) col = MATRIX_COLS - 1 - col;
               idx = col + row * MATRIX_COLS;
               frame_pixels[idx] = {w[26:19], w[34:27], w[42:35]};
               request_model = 1'b1;
            end
         end
         CMD_CLEAR: begin
            foreach (frame_pixels[i]) frame_pixels[i] = '0;
            request_model = 1'b1;
         end
         CMD_TICK: begin
            if (request_model && busy_model == 4'd0) begin
               request_model = 1'b0;
               busy_model = ALL_BUSY;
               st.start = 1'b1;
            end
         end
         CMD_CHANNEL_DONE: begin
            if (int'(w[44:43]) < NUM_CHANNELS) busy_model = busy_model ^ (4'd1 << w[44:43]);
         end
         CMD_READ_ENTRY: st.compare = slot_compare(int'(w[44:43]), int'(w[55:45]));
         default: ;
      endcase
      st.busy = busy_model;
      st.request = request_model;
   endtask

   // bias reads toward slots of real pixels; keep some noise and out-of-range writes
   function automatic logic [REQ_TDATA_W-1:0] random_word();
      int          pick;
      logic [2:0]  cmd;
      logic [7:0]  col;
      logic [7:0]  row;
      logic [1:0]  ch;
      logic [10:0] slot;
      int          pix;
      pick = $urandom_range(99);
      col  = 8'($urandom_range(255));
      row  = 8'($urandom_range(255));
      ch   = 2'($urandom_range(3));
      slot = 11'($urandom_range(2047));
      if (pick < 30) begin
         cmd = CMD_SET_PIXEL;
         if ($urandom_range(99) < 85) begin
            col = 8'($urandom_range(MATRIX_COLS - 1));
            row = 8'($urandom_range(MATRIX_ROWS - 1));
         end
      end else if (pick < 33) begin
         cmd = CMD_CLEAR;
      end else if (pick < 45) begin
         cmd = CMD_TICK;
      end else if (pick < 60) begin
         cmd = CMD_CHANNEL_DONE;
      end else if (pick < 95) begin
         cmd = CMD_READ_ENTRY;
         if ($urandom_range(99) < 60) begin
            pix  = $urandom_range(PIXEL_COUNT - 1);
            ch   = 2'(pix / PIX_PER_CH);
            slot = 11'((pix % PIX_PER_CH) * BITS_PER_PIXEL
                       + $urandom_range(BITS_PER_PIXEL - 1));
         end else if ($urandom_range(99) < 70) begin
            slot = 11'($urandom_range(DATA_SLOTS + 3 * BITS_PER_PIXEL - 1));
         end
      end else begin
         cmd = 3'($urandom_range(7, 5));
      end
      return pack_word(cmd, col, row, 8'($urandom_range(255)), 8'($urandom_range(255)),
                       8'($urandom_range(255)), ch, slot);
   endfunction

   task automatic drain_all();
      do @(negedge clock);
      while (outgoing_words.size() != 0 || req_tvalid || status_expected.size() != 0);
   endtask

   always @(posedge clock) begin
      strip_status_type st;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            apply_command(req_tdata, st);
            status_expected.push_back(st);
         end
         if (!req_tvalid || req_tready) begin
            if (outgoing_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata <= outgoing_words.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      strip_status_type want;
      strip_status_type got;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         if (rsp_tvalid && rsp_tready) begin
            got.compare = rsp_tdata[2:0];
            got.start   = rsp_tdata[3];
            got.busy    = rsp_tdata[7:4];
            got.request = rsp_tdata[8];
            if (status_expected.size() == 0) begin
               if (fault_count < 10) $display("unexpected word: %h", rsp_tdata);
               fault_count++;
            end else begin
               want = status_expected.pop_front();
               if (got !== want) begin
                  if (fault_count < 10)
                     $display("mismatch: expected cmp=%0d start=%0d busy=%h req=%0d, %s",
                              want.compare, want.start, want.busy, want.request,
                              $sformatf("got cmp=%0d start=%0d busy=%h req=%0d",
                                        got.compare, got.start, got.busy, got.request));
                  fault_count++;
               end
            end
         end
      end
   end

   initial begin
      #2000000;
      $display("Some tests failed");
      $finish;
   end

   initial begin
      foreach (frame_pixels[i]) frame_pixels[i] = '0;
      request_model = 1'b1;
      busy_model = 4'd0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: reset state, launch/busy rules, mirroring, range edges, tail, unused codes
      outgoing_words.push_back(pack_word(CMD_READ_ENTRY, 0, 0, 0, 0, 0, 0, 0));
      outgoing_words.push_back(pack_word(CMD_TICK, 0, 0, 0, 0, 0, 0, 0));
      outgoing_words.push_back(pack_word(CMD_SET_PIXEL, 0, 0, 8'hFF, 8'hFF, 8'hFF, 0, 0));
      outgoing_words.push_back(pack_word(CMD_TICK, 0, 0, 0, 0, 0, 0, 0));
      outgoing_words.push_back(pack_word(CMD_CHANNEL_DONE, 0, 0, 0, 0, 0, 0, 0));
      outgoing_words.push_back(pack_word(CMD_CHANNEL_DONE, 0, 0, 0, 0, 0, 1, 0));
      outgoing_words.push_back(pack_word(CMD_CHANNEL_DONE, 0, 0, 0, 0, 0, 2, 0));
      outgoing_words.push_back(pack_word(CMD_CHANNEL_DONE, 0, 0, 0, 0, 0, 3, 0));
      outgoing_words.push_back(pack_word(CMD_TICK, 0, 0, 0, 0, 0, 0, 0));
      outgoing_words.push_back(pack_word(CMD_CHANNEL_DONE, 0, 0, 0, 0, 0, 3, 0));
      outgoing_words.push_back(pack_word(CMD_CHANNEL_DONE, 0, 0, 0, 0, 0, 3, 0));
      outgoing_words.push_back(pack_word(CMD_SET_PIXEL, 15, 15, 8'h80, 8'h01, 8'hA5, 0, 0));
      outgoing_words.push_back(pack_word(CMD_SET_PIXEL, 16, 3, 8'hFF, 8'hFF, 8'hFF, 0, 0));
      outgoing_words.push_back(pack_word(CMD_SET_PIXEL, 255, 0, 8'hFF, 8'hFF, 8'hFF, 0, 0));
      outgoing_words.push_back(pack_word(CMD_SET_PIXEL, 2, 16, 8'hFF, 8'hFF, 8'hFF, 0, 0));
      outgoing_words.push_back(pack_word(CMD_SET_PIXEL, 2, 255, 8'hFF, 8'hFF, 8'hFF, 0, 0));
      outgoing_words.push_back(pack_word(CMD_READ_ENTRY, 0, 0, 0, 0, 0, 3, 1535 - 23));
      outgoing_words.push_back(pack_word(CMD_READ_ENTRY, 0, 0, 0, 0, 0, 3, 1535 - 8));
      outgoing_words.push_back(pack_word(CMD_READ_ENTRY, 0, 0, 0, 0, 0, 0, 7));
      outgoing_words.push_back(pack_word(CMD_READ_ENTRY, 0, 0, 0, 0, 0, 3, 1536));
      outgoing_words.push_back(pack_word(CMD_READ_ENTRY, 0, 0, 0, 0, 0, 3, 1607));
      outgoing_words.push_back(pack_word(CMD_READ_ENTRY, 0, 0, 0, 0, 0, 3, 2047));
      outgoing_words.push_back(pack_word(3'd5, 0, 0, 0, 0, 0, 0, 0));
      outgoing_words.push_back(pack_word(3'd7, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 3, 2047));
      outgoing_words.push_back(pack_word(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0));
      outgoing_words.push_back(pack_word(CMD_READ_ENTRY, 0, 0, 0, 0, 0, 0, 0));

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
            default: begin send_idle_pct = 28; recv_stall_pct = 28; end
         endcase
         for (int n = 0; n < 160; n++) outgoing_words.push_back(random_word());
         // hold the sender until every outstanding status word has come back
         drain_all();
      end

      repeat (20) @(posedge clock);
      if (fault_count == 0 && status_expected.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule

@@ filelist.f @@
+incdir+rtl
rtl/wmfb_pkg.sv
rtl/wmfb_ctrl.sv
rtl/wmfb_store.sv
rtl/wmfb_out.sv
rtl/ws2812_matrix_frame_buffer.sv
rtl/wmfb_checker.sv
dv/tb.sv
